[src/dqpd_pkg.sv]
// Package for the pulse dialer: types, constants, command and status structs.
`timescale 1ns / 1ps

package dqpd_pkg;

    localparam int QUEUE_DEPTH = 32;
    localparam int PTR_W       = $clog2(QUEUE_DEPTH);

    localparam int ON_W     = 8;
    localparam int PERIOD_W = 13;
    localparam int AMP_W    = 15;
    localparam int KEY_W    = 4;
    localparam int COUNT_W  = 4;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 15;

    localparam int RATE_NUMERATOR = 8000;

    localparam logic [KEY_W-1:0] CODE_STAR  = 4'd10;
    localparam logic [KEY_W-1:0] CODE_HASH  = 4'd11;
    localparam logic [KEY_W-1:0] DIGIT_LIMIT = 4'd10;
    localparam logic [COUNT_W-1:0] PULSES_FOR_ZERO = 4'd10;

    localparam logic [ON_W-1:0]     RST_ON_SAMPLES      = 8'd8;
    localparam logic [PERIOD_W-1:0] RST_DEFAULT_PERIOD  = 13'd800;
    localparam logic [PERIOD_W-1:0] RST_PAUSE_SAMPLES   = 13'd4000;
    localparam logic [AMP_W-1:0]    RST_PULSE_AMPLITUDE = 15'd32767;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_ON_SAMPLES      = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DEFAULT_PERIOD  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_PAUSE_SAMPLES   = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_PULSE_AMPLITUDE = 2'd3;

    // Input word kinds carried in tuser
    localparam logic CMD_TICK = 1'b0;
    localparam logic CMD_PUSH = 1'b1;

    typedef enum logic [2:0] {
        MODE_WAIT_STAR = 3'd0,
        MODE_IDLE      = 3'd1,
        MODE_PLAYING   = 3'd2,
        MODE_RATE      = 3'd3,
        MODE_PAUSE     = 3'd4
    } mode_t;

    typedef enum logic {
        ST_IDLE = 1'b0,
        ST_EXEC = 1'b1
    } ctrl_state_t;

    typedef struct packed {
        logic push_en;
        logic tick_en;
    } dp_cmd_t;

    typedef struct packed {
        logic out_full;
    } dp_status_t;

    function automatic logic [PTR_W-1:0] next_pos(input logic [PTR_W-1:0] p);
        logic [PTR_W-1:0] r;
        if (p == PTR_W'(QUEUE_DEPTH - 1))
            r = '0;
        else
            r = p + 1'b1;
        return r;
    endfunction

    // Period for a rate digit: 8000 / d, digits one to nine
    function automatic logic [PERIOD_W-1:0] rate_period(input logic [KEY_W-1:0] d);
        logic [PERIOD_W-1:0] r;
        case (d)
            4'd1:    r = PERIOD_W'(RATE_NUMERATOR / 1);
            4'd2:    r = PERIOD_W'(RATE_NUMERATOR / 2);
            4'd3:    r = PERIOD_W'(RATE_NUMERATOR / 3);
            4'd4:    r = PERIOD_W'(RATE_NUMERATOR / 4);
            4'd5:    r = PERIOD_W'(RATE_NUMERATOR / 5);
            4'd6:    r = PERIOD_W'(RATE_NUMERATOR / 6);
            4'd7:    r = PERIOD_W'(RATE_NUMERATOR / 7);
            4'd8:    r = PERIOD_W'(RATE_NUMERATOR / 8);
            4'd9:    r = PERIOD_W'(RATE_NUMERATOR / 9);
            default: r = '0;
        endcase
        return r;
    endfunction

endpackage

[src/dqpd_ctrl.sv]
// Controller: sequences input words into queue pushes and sample evaluations.
`timescale 1ns / 1ps

module dqpd_ctrl
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    input  logic                in_command,
    output logic                in_ready,
    input  logic                out_ready,
    input  dqpd_pkg::dp_status_t status,
    output dqpd_pkg::dp_cmd_t    cmd
);

    dqpd_pkg::ctrl_state_t state_reg;
    dqpd_pkg::ctrl_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= dqpd_pkg::ST_IDLE;
        else
            state_reg <= state_next;
    end

    always_comb
    begin
        state_next  = state_reg;
        in_ready    = 1'b0;
        cmd.push_en = 1'b0;
        cmd.tick_en = 1'b0;
        case (state_reg)
            dqpd_pkg::ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    if (in_command == dqpd_pkg::CMD_PUSH)
                        cmd.push_en = 1'b1;
                    else
                        state_next = dqpd_pkg::ST_EXEC;
                end
            end
            dqpd_pkg::ST_EXEC:
            begin
                // hold until the output register is free or drains this cycle
                if (!status.out_full || out_ready)
                begin
                    cmd.tick_en = 1'b1;
                    state_next  = dqpd_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = dqpd_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

[src/dqpd_datapath.sv]
// Datapath: code queue, dialer state, configuration and output register.
`timescale 1ns / 1ps

module dqpd_datapath
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  dqpd_pkg::dp_cmd_t                   cmd,
    output dqpd_pkg::dp_status_t                status,
    input  logic [dqpd_pkg::KEY_W-1:0]          key_code,
    input  logic                                cfg_we,
    input  logic [dqpd_pkg::CFG_IDX_W-1:0]      cfg_addr,
    input  logic [dqpd_pkg::CFG_DATA_W-1:0]     cfg_data,
    input  logic                                out_ready,
    output logic                                out_valid,
    output logic [dqpd_pkg::AMP_W-1:0]          sample_out
);

    logic [dqpd_pkg::KEY_W-1:0] code_store [dqpd_pkg::QUEUE_DEPTH];
    logic [dqpd_pkg::KEY_W-1:0] code_rd_reg;

    logic [dqpd_pkg::PTR_W-1:0]    write_pos_reg, write_pos_next;
    logic [dqpd_pkg::PTR_W-1:0]    read_pos_reg, read_pos_next;
    dqpd_pkg::mode_t               mode_reg, mode_next;
    logic [dqpd_pkg::PERIOD_W-1:0] sample_pos_reg, sample_pos_next;
    logic [dqpd_pkg::COUNT_W-1:0]  pulses_done_reg, pulses_done_next;
    logic [dqpd_pkg::COUNT_W-1:0]  pulses_wanted_reg, pulses_wanted_next;
    logic [dqpd_pkg::PERIOD_W-1:0] period_len_reg, period_len_next;

    logic [dqpd_pkg::ON_W-1:0]     on_samples_reg;
    logic [dqpd_pkg::PERIOD_W-1:0] default_period_reg;
    logic [dqpd_pkg::PERIOD_W-1:0] pause_samples_reg;
    logic [dqpd_pkg::AMP_W-1:0]    pulse_amplitude_reg;

    logic                       out_valid_reg, out_valid_next;
    logic [dqpd_pkg::AMP_W-1:0] sample_reg, sample_next;

    // Queue storage; the read port follows read_pos every cycle
    always_ff @(posedge clk)
    begin
        if (cmd.push_en)
            code_store[write_pos_reg] <= key_code;
        code_rd_reg <= code_store[read_pos_reg];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            on_samples_reg      <= dqpd_pkg::RST_ON_SAMPLES;
            default_period_reg  <= dqpd_pkg::RST_DEFAULT_PERIOD;
            pause_samples_reg   <= dqpd_pkg::RST_PAUSE_SAMPLES;
            pulse_amplitude_reg <= dqpd_pkg::RST_PULSE_AMPLITUDE;
        end
        else if (cfg_we)
        begin
            case (cfg_addr)
                dqpd_pkg::CFG_ON_SAMPLES:
                    on_samples_reg <= cfg_data[dqpd_pkg::ON_W-1:0];
                dqpd_pkg::CFG_DEFAULT_PERIOD:
                    default_period_reg <= cfg_data[dqpd_pkg::PERIOD_W-1:0];
                dqpd_pkg::CFG_PAUSE_SAMPLES:
                    pause_samples_reg <= cfg_data[dqpd_pkg::PERIOD_W-1:0];
                dqpd_pkg::CFG_PULSE_AMPLITUDE:
                    pulse_amplitude_reg <= cfg_data[dqpd_pkg::AMP_W-1:0];
                default:
                    on_samples_reg <= on_samples_reg;
            endcase
        end
    end

    always_comb
    begin
        logic [dqpd_pkg::PTR_W-1:0]    wp_adv;
        logic [dqpd_pkg::COUNT_W-1:0]  pd_inc;
        logic                          empty;
        write_pos_next     = write_pos_reg;
        read_pos_next      = read_pos_reg;
        mode_next          = mode_reg;
        sample_pos_next    = sample_pos_reg;
        pulses_done_next   = pulses_done_reg;
        pulses_wanted_next = pulses_wanted_reg;
        period_len_next    = period_len_reg;
        sample_next        = '0;
        wp_adv             = dqpd_pkg::next_pos(write_pos_reg);
        empty              = (read_pos_reg == write_pos_reg);
        pd_inc             = '0;

        if (cmd.push_en)
        begin
            write_pos_next = wp_adv;
            // full queue: drop the oldest code
            if (wp_adv == read_pos_reg)
                read_pos_next = dqpd_pkg::next_pos(read_pos_reg);
        end
        else if (cmd.tick_en)
        begin
            if (mode_reg != dqpd_pkg::MODE_PLAYING && !empty)
            begin
                if (mode_reg == dqpd_pkg::MODE_PAUSE)
                begin
                    if (sample_pos_reg >= pause_samples_reg)
                    begin
                        mode_next       = dqpd_pkg::MODE_IDLE;
                        sample_pos_next = '0;
                    end
                    else
                        sample_pos_next = sample_pos_reg + 1'b1;
                end
                else
                begin
                    read_pos_next = dqpd_pkg::next_pos(read_pos_reg);
                    if (mode_reg == dqpd_pkg::MODE_WAIT_STAR)
                    begin
                        if (code_rd_reg == dqpd_pkg::CODE_STAR)
                            mode_next = dqpd_pkg::MODE_IDLE;
                    end
                    else if (code_rd_reg == dqpd_pkg::CODE_HASH)
                    begin
                        mode_next       = dqpd_pkg::MODE_WAIT_STAR;
                        period_len_next = default_period_reg;
                    end
                    else if (mode_reg == dqpd_pkg::MODE_IDLE)
                    begin
                        if (code_rd_reg == dqpd_pkg::CODE_STAR)
                            mode_next = dqpd_pkg::MODE_RATE;
                        else if (code_rd_reg < dqpd_pkg::DIGIT_LIMIT)
                        begin
                            mode_next          = dqpd_pkg::MODE_PLAYING;
                            pulses_wanted_next = (code_rd_reg == '0)
                                ? dqpd_pkg::PULSES_FOR_ZERO : code_rd_reg;
                            pulses_done_next   = '0;
                            sample_pos_next    = '0;
                        end
                    end
                    else if (mode_reg == dqpd_pkg::MODE_RATE)
                    begin
                        if (code_rd_reg < dqpd_pkg::DIGIT_LIMIT)
                            period_len_next = (code_rd_reg == '0)
                                ? default_period_reg : dqpd_pkg::rate_period(code_rd_reg);
                        mode_next = dqpd_pkg::MODE_IDLE;
                    end
                end
            end

            if (mode_next == dqpd_pkg::MODE_PLAYING)
            begin
                pd_inc = pulses_done_next + 1'b1;
                if (sample_pos_next < dqpd_pkg::PERIOD_W'(on_samples_reg))
                begin
                    sample_next     = pulse_amplitude_reg;
                    sample_pos_next = sample_pos_next + 1'b1;
                end
                else if (sample_pos_next < period_len_reg)
                    sample_pos_next = sample_pos_next + 1'b1;
                else
                begin
                    // end of one pulse period
                    sample_pos_next  = '0;
                    pulses_done_next = pd_inc;
                    if (pd_inc >= pulses_wanted_next)
                    begin
                        pulses_done_next = '0;
                        mode_next        = dqpd_pkg::MODE_PAUSE;
                    end
                end
            end
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.tick_en)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            write_pos_reg     <= '0;
            read_pos_reg      <= '0;
            mode_reg          <= dqpd_pkg::MODE_WAIT_STAR;
            sample_pos_reg    <= '0;
            pulses_done_reg   <= '0;
            pulses_wanted_reg <= '0;
            period_len_reg    <= dqpd_pkg::RST_DEFAULT_PERIOD;
            out_valid_reg     <= 1'b0;
        end
        else
        begin
            write_pos_reg     <= write_pos_next;
            read_pos_reg      <= read_pos_next;
            mode_reg          <= mode_next;
            sample_pos_reg    <= sample_pos_next;
            pulses_done_reg   <= pulses_done_next;
            pulses_wanted_reg <= pulses_wanted_next;
            period_len_reg    <= period_len_next;
            out_valid_reg     <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.tick_en)
            sample_reg <= sample_next;
    end

    assign status.out_full = out_valid_reg;
    assign out_valid       = out_valid_reg;
    assign sample_out      = sample_reg;

    a_play_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        mode_reg == dqpd_pkg::MODE_PLAYING |->
            (pulses_wanted_reg != '0 && pulses_wanted_reg <= dqpd_pkg::PULSES_FOR_ZERO))
        else $error("pulse count out of range while playing");

    a_play_progress: assert property (@(posedge clk) disable iff (!rst_n)
        mode_reg == dqpd_pkg::MODE_PLAYING |-> pulses_done_reg < pulses_wanted_reg)
        else $error("pulses done reached wanted without leaving play");

    a_push_not_empty: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.push_en |=> read_pos_reg != write_pos_reg)
        else $error("queue empty right after a push");

    a_tick_loads_output: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.tick_en |=> out_valid_reg)
        else $error("evaluated sample not presented");

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.tick_en |-> (!out_valid_reg || out_ready))
        else $error("output register overwritten while still held");

endmodule

[src/digit_queue_pulse_dialer_core.sv]
// Top level of the keypad-code queue pulse dialer.
`timescale 1ns / 1ps

// A push word (tuser = 1) stores its key code in the 32-entry ring queue in
// the cycle it is accepted and leaves the block ready again in the next cycle.
// A tick word (tuser = 0) is accepted in controller state ST_IDLE, while the
// registered queue read port presents the oldest code, and is evaluated in
// ST_EXEC, which updates the dialer state and loads the sample into the
// output register. Evaluation waits while the output register still holds an
// untaken sample, so one sample can stand at the output while the next words
// arrive. A full queue drops its oldest code; it holds at most 31 codes. The
// queue needs no clearing after reset. Write configuration only while idle.

module digit_queue_pulse_dialer_core
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    input  logic [7:0]                          s_axis_tdata,  // [3:0] key_code
    input  logic                                s_axis_tuser,  // [0] command
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    output logic [15:0]                         m_axis_tdata,  // [14:0] sample_out
    input  logic                                cfg_we,
    input  logic [dqpd_pkg::CFG_IDX_W-1:0]      cfg_addr,
    input  logic [dqpd_pkg::CFG_DATA_W-1:0]     cfg_data
);

    dqpd_pkg::dp_cmd_t          cmd;
    dqpd_pkg::dp_status_t       status;
    logic [dqpd_pkg::AMP_W-1:0] sample_out;

    dqpd_ctrl u_ctrl
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (s_axis_tvalid),
        .in_command (s_axis_tuser),
        .in_ready   (s_axis_tready),
        .out_ready  (m_axis_tready),
        .status     (status),
        .cmd        (cmd)
    );

    dqpd_datapath u_datapath
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .status     (status),
        .key_code   (s_axis_tdata[dqpd_pkg::KEY_W-1:0]),
        .cfg_we     (cfg_we),
        .cfg_addr   (cfg_addr),
        .cfg_data   (cfg_data),
        .out_ready  (m_axis_tready),
        .out_valid  (m_axis_tvalid),
        .sample_out (sample_out)
    );

    assign m_axis_tdata = {1'b0, sample_out};

endmodule
